### hw/rtl/sabr_pkg.sv
// shared types, register indexes and constant tables for the sabr path stepper
// no dependencies; imported by every other file of the block
package sabr_pkg;

    localparam logic [30:0] PRICE_MAX = 31'h7FFF_FFFF;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [16:0] BETA_ONE  = 17'd65536;
    localparam logic [30:0] Q16_ONE   = 31'd65536;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [40:0] BM_CAP    = 41'h100_0000_0000;
    localparam logic signed [48:0] EXP_LIM = 49'sd2097152;

    localparam logic [2:0] REG_INITIAL_PRICE     = 3'd0;
    localparam logic [2:0] REG_INITIAL_VOL       = 3'd1;
    localparam logic [2:0] REG_GROWTH_FACTOR     = 3'd2;
    localparam logic [2:0] REG_SQRT_STEP         = 3'd3;
    localparam logic [2:0] REG_ELASTICITY        = 3'd4;
    localparam logic [2:0] REG_VOL_DRIFT         = 3'd5;
    localparam logic [2:0] REG_VOL_WEIGHT_FIRST  = 3'd6;
    localparam logic [2:0] REG_VOL_WEIGHT_SECOND = 3'd7;

    typedef struct packed {
        logic signed [31:0] normal_first;
        logic signed [31:0] normal_second;
        logic               path_start;
        logic               path_end;
    } t_in_item;

    typedef struct packed {
        logic [30:0] final_price;
        logic [30:0] final_vol;
        logic        price_clamped;
    } t_out_item;

    typedef struct packed {
        logic [30:0]        initial_price;
        logic [30:0]        initial_vol;
        logic [30:0]        growth_factor;
        logic [30:0]        sqrt_step;
        logic [16:0]        elasticity;
        logic signed [31:0] vol_drift;
        logic signed [31:0] vol_weight_first;
        logic signed [31:0] vol_weight_second;
    } t_cfg;

    // head of the step queue as seen by the back end
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_q_view;

    function automatic logic [63:0] f_isqrt(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bv;
        x   = x_in;
        res = 64'd0;
        bv  = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (x >= res + bv) begin
                x   = x - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    // factors 2^(2^-k), k = 1..16, in Q1.30, each by truncated square root
    function automatic logic [16*31-1:0] f_exp2_table();
        logic [63:0]        t;
        logic [16*31-1:0]   tab;
        t   = 64'h8000_0000;
        tab = '0;
        for (int k = 0; k < 16; k++) begin
            t = f_isqrt(t << 30);
            tab[k*31 +: 31] = t[30:0];
        end
        return tab;
    endfunction

    localparam logic [16*31-1:0] EXP2_TABLE = f_exp2_table();

    function automatic logic [30:0] f_exp2_factor(input logic [3:0] idx);
        return EXP2_TABLE[32'(idx) * 31 +: 31];
    endfunction

endpackage

### hw/rtl/sabr_front.sv
// front end: two-entry step queue between the input transfer and the stepper
// depends on sabr_pkg
module sabr_front import sabr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_pop,
    output t_q_view  o_q
);

    t_in_item    r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        do_push, do_pop;

    assign o_full    = (r_count == 2'd2);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && (r_count != 2'd0);
    assign o_q.valid = (r_count != 2'd0);
    assign o_q.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hw/rtl/sabr_back.sv
// back end: step sequencer around one shared 32x32 multiplier, plus result register
// depends on sabr_pkg; fed by sabr_front
module sabr_back import sabr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_view   i_q,
    output logic      o_q_pop,
    output t_out_item o_out,
    output logic      o_out_valid,
    input  logic      i_pop
);

    localparam logic [3:0] P_IDLE = 4'd0;
    localparam logic [3:0] P_NORM = 4'd1;
    localparam logic [3:0] P_LOG  = 4'd2;
    localparam logic [3:0] P_Y    = 4'd3;
    localparam logic [3:0] P_EXP  = 4'd4;
    localparam logic [3:0] P_Z1   = 4'd5;
    localparam logic [3:0] P_VP   = 4'd6;
    localparam logic [3:0] P_BM   = 4'd7;
    localparam logic [3:0] P_A    = 4'd8;
    localparam logic [3:0] P_S1   = 4'd9;
    localparam logic [3:0] P_S2   = 4'd10;
    localparam logic [3:0] P_YV   = 4'd11;
    localparam logic [3:0] P_NV   = 4'd12;

    logic [3:0]         r_phase, n_phase;
    logic [3:0]         r_cnt, n_cnt;
    logic               r_half, n_half;
    logic               r_second, n_second;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    logic [30:0]        r_price, n_price;
    logic [30:0]        r_vol, n_vol;
    logic               r_clamp, n_clamp;
    logic [31:0]        r_n1, n_n1;
    logic [31:0]        r_n2, n_n2;
    logic               r_last, n_last;
    logic [16:0]        r_beta, n_beta;
    logic [30:0]        r_m, n_m;
    logic [4:0]         r_p, n_p;
    logic [15:0]        r_frac, n_frac;
    logic [6:0]         r_i, n_i;
    logic [15:0]        r_f, n_f;
    logic [30:0]        r_r, n_r;
    logic [30:0]        r_pw, n_pw;
    logic [45:0]        r_z1mag, n_z1mag;
    logic [45:0]        r_vp, n_vp;
    logic [91:0]        r_acc, n_acc;
    logic [45:0]        r_a, n_a;
    logic [48:0]        r_ex, n_ex;
    logic [63:0]        r_prod;

    logic [31:0]        mul_a, mul_b;
    logic [16:0]        beta_in;
    logic [30:0]        ld_price;
    logic [4:0]         norm_sh;
    logic               norm_top_zero;
    logic [31:0]        log_q;
    logic [5:0]         p_m16;
    logic [21:0]        log_val, log_neg;
    logic [20:0]        log_mag;
    logic [21:0]        y_val;
    logic               exp_bit;
    logic [30:0]        exp_r_new;
    logic [6:0]         pw_amt;
    logic [31:0]        n1_mag, n2_mag, w1_mag, w2_mag;
    logic [48:0]        s_mag, s_term, ex_neg;
    logic               s_neg;
    logic signed [48:0] ex_sum;
    logic [21:0]        ex_mag;
    logic [22:0]        yv_val;
    logic [91:0]        bm_pp;
    logic [40:0]        bm;
    logic signed [47:0] sum_val;
    logic               price_neg, price_big;
    logic [30:0]        new_price;
    logic               nv_ge;
    logic [6:0]         nv_s, nv_t;
    logic [77:0]        nv_wide;
    logic [61:0]        nv_shr;
    logic               nv_sat;
    logic [30:0]        nv;
    logic               out_free;
    logic               commit;

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_pop;

    assign beta_in  = (i_cfg.elasticity > BETA_ONE) ? BETA_ONE : i_cfg.elasticity;
    assign ld_price = i_q.item.path_start ? i_cfg.initial_price : r_price;

    // leading-zero search over five halving steps
    assign norm_sh       = 5'd16 >> r_cnt;
    assign norm_top_zero = ((r_m >> (5'd31 - norm_sh)) == 31'd0);

    assign log_q   = r_prod[61:30];
    assign p_m16   = {1'b0, r_p} - 6'd16;
    assign log_val = {p_m16, r_frac};
    assign log_neg = 22'd0 - log_val;
    assign log_mag = log_val[21] ? log_neg[20:0] : log_val[20:0];
    assign y_val   = log_val[21] ? (22'd0 - {1'b0, r_prod[36:16]}) : {1'b0, r_prod[36:16]};

    assign exp_bit   = r_f[4'd15 - r_cnt];
    assign exp_r_new = r_half ? r_prod[60:30] : r_r;
    assign pw_amt    = 7'd14 - r_i;

    assign n1_mag = r_n1[31] ? (32'd0 - r_n1) : r_n1;
    assign n2_mag = r_n2[31] ? (32'd0 - r_n2) : r_n2;
    assign w1_mag = i_cfg.vol_weight_first[31] ? (32'd0 - i_cfg.vol_weight_first)
                                               : i_cfg.vol_weight_first;
    assign w2_mag = i_cfg.vol_weight_second[31] ? (32'd0 - i_cfg.vol_weight_second)
                                                : i_cfg.vol_weight_second;

    assign s_neg  = (r_phase == P_S1) ? (i_cfg.vol_weight_first[31] ^ r_n1[31])
                                      : (i_cfg.vol_weight_second[31] ^ r_n2[31]);
    assign s_mag  = {2'b00, r_prod[62:16]};
    assign s_term = s_neg ? (49'd0 - s_mag) : s_mag;
    assign ex_sum = $signed(r_ex + s_term);
    assign ex_neg = 49'd0 - r_ex;
    assign ex_mag = r_ex[48] ? ex_neg[21:0] : r_ex[21:0];
    assign yv_val = r_ex[48] ? (23'd0 - {1'b0, r_prod[51:30]}) : {1'b0, r_prod[51:30]};

    // partial products of the 46x46 noise product
    always_comb begin
        case (r_cnt[1:0])
            2'd1, 2'd2: bm_pp = {46'd0, r_prod[45:0]} << 23;
            2'd3:       bm_pp = {46'd0, r_prod[45:0]} << 46;
            default:    bm_pp = {46'd0, r_prod[45:0]};
        endcase
    end

    assign bm        = (|r_acc[91:56]) ? BM_CAP : {1'b0, r_acc[55:16]};
    assign sum_val   = r_n1[31] ? ($signed({2'b00, r_a}) - $signed({7'd0, bm}))
                                : ($signed({2'b00, r_a}) + $signed({7'd0, bm}));
    assign price_neg = sum_val[47];
    assign price_big = !sum_val[47] && (sum_val[46:31] != 16'd0);
    assign new_price = price_neg ? 31'd0 : (price_big ? PRICE_MAX : sum_val[30:0]);

    // volatility times the exp2 mantissa, times 2^(i-30), floored and saturated
    assign nv_ge   = ($signed(r_i) >= 7'sd30);
    assign nv_s    = r_i - 7'd30;
    assign nv_t    = 7'd30 - r_i;
    assign nv_wide = {16'd0, r_prod[61:0]} << nv_s[4:0];
    assign nv_shr  = r_prod[61:0] >> nv_t;
    assign nv_sat  = nv_ge ? (|nv_wide[77:31]) : (|nv_shr[61:31]);
    assign nv      = nv_sat ? PRICE_MAX : (nv_ge ? nv_wide[30:0] : nv_shr[30:0]);

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_phase)
            P_LOG: begin
                mul_a = {1'b0, r_m};
                mul_b = {1'b0, r_m};
            end
            P_Y: begin
                mul_a = {11'd0, log_mag};
                mul_b = {15'd0, r_beta};
            end
            P_EXP: begin
                mul_a = {1'b0, r_r};
                mul_b = {1'b0, f_exp2_factor(r_cnt)};
            end
            P_Z1: begin
                mul_a = n1_mag;
                mul_b = {1'b0, i_cfg.sqrt_step};
            end
            P_VP: begin
                mul_a = {1'b0, r_vol};
                mul_b = {1'b0, r_pw};
            end
            P_BM: begin
                mul_a = r_cnt[1] ? {9'd0, r_vp[45:23]} : {9'd0, r_vp[22:0]};
                mul_b = r_cnt[0] ? {9'd0, r_z1mag[45:23]} : {9'd0, r_z1mag[22:0]};
            end
            P_A: begin
                mul_a = {1'b0, r_price};
                mul_b = {1'b0, i_cfg.growth_factor};
            end
            P_S1: begin
                mul_a = w1_mag;
                mul_b = n1_mag;
            end
            P_S2: begin
                mul_a = w2_mag;
                mul_b = n2_mag;
            end
            P_YV: begin
                mul_a = {10'd0, ex_mag};
                mul_b = {1'b0, LOG2E_Q30};
            end
            P_NV: begin
                mul_a = {1'b0, r_vol};
                mul_b = {1'b0, r_r};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_half      = r_half;
        n_second    = r_second;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        n_price     = r_price;
        n_vol       = r_vol;
        n_clamp     = r_clamp;
        n_n1        = r_n1;
        n_n2        = r_n2;
        n_last      = r_last;
        n_beta      = r_beta;
        n_m         = r_m;
        n_p         = r_p;
        n_frac      = r_frac;
        n_i         = r_i;
        n_f         = r_f;
        n_r         = r_r;
        n_pw        = r_pw;
        n_z1mag     = r_z1mag;
        n_vp        = r_vp;
        n_acc       = r_acc;
        n_a         = r_a;
        n_ex        = r_ex;
        o_q_pop     = 1'b0;
        commit      = 1'b0;
        case (r_phase)
            P_IDLE: begin
                if (i_q.valid) begin
                    o_q_pop = 1'b1;
                    n_n1    = i_q.item.normal_first;
                    n_n2    = i_q.item.normal_second;
                    n_last  = i_q.item.path_end;
                    n_beta  = beta_in;
                    if (i_q.item.path_start) begin
                        n_price = i_cfg.initial_price;
                        n_vol   = i_cfg.initial_vol;
                        n_clamp = 1'b0;
                    end
                    n_m    = ld_price;
                    n_p    = 5'd30;
                    n_frac = 16'd0;
                    n_cnt  = 4'd0;
                    n_half = 1'b0;
                    if (ld_price == 31'd0) begin
                        // zero price: power is one only for zero elasticity
                        n_pw    = (beta_in == 17'd0) ? Q16_ONE : 31'd0;
                        n_phase = P_Z1;
                    end else begin
                        n_phase = P_NORM;
                    end
                end
            end
            P_NORM: begin
                if (norm_top_zero) begin
                    n_m = r_m << norm_sh;
                    n_p = r_p - norm_sh;
                end
                if (r_cnt == 4'd4) begin
                    n_cnt   = 4'd0;
                    n_phase = P_LOG;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            P_LOG: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    n_frac = {r_frac[14:0], log_q[31]};
                    n_m    = log_q[31] ? log_q[31:1] : log_q[30:0];
                    if (r_cnt == 4'd15) begin
                        n_cnt   = 4'd0;
                        n_phase = P_Y;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            P_Y: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half   = 1'b0;
                    n_i      = {y_val[21], y_val[21:16]};
                    n_f      = y_val[15:0];
                    n_r      = Q30_ONE;
                    n_second = 1'b0;
                    n_cnt    = 4'd0;
                    n_phase  = P_EXP;
                end
            end
            P_EXP: begin
                // a clear fraction bit skips its multiply
                if (!r_half && exp_bit) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    n_r    = exp_r_new;
                    if (r_cnt == 4'd15) begin
                        n_cnt = 4'd0;
                        if (r_second) begin
                            n_phase = P_NV;
                        end else begin
                            n_pw    = exp_r_new >> pw_amt[4:0];
                            n_phase = P_Z1;
                        end
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            P_Z1: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half  = 1'b0;
                    n_z1mag = r_prod[61:16];
                    n_phase = P_VP;
                end
            end
            P_VP: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half  = 1'b0;
                    n_vp    = r_prod[61:16];
                    n_cnt   = 4'd0;
                    n_phase = P_BM;
                end
            end
            P_BM: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    n_acc  = (r_cnt == 4'd0) ? bm_pp : (r_acc + bm_pp);
                    if (r_cnt == 4'd3) begin
                        n_cnt   = 4'd0;
                        n_phase = P_A;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            P_A: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half  = 1'b0;
                    n_a     = r_prod[61:16];
                    n_phase = P_S1;
                end
            end
            P_S1: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half  = 1'b0;
                    n_ex    = {{17{i_cfg.vol_drift[31]}}, i_cfg.vol_drift} + s_term;
                    n_phase = P_S2;
                end
            end
            P_S2: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    if (ex_sum > EXP_LIM) begin
                        n_ex = EXP_LIM;
                    end else if (ex_sum < -EXP_LIM) begin
                        n_ex = -EXP_LIM;
                    end else begin
                        n_ex = ex_sum;
                    end
                    n_phase = P_YV;
                end
            end
            P_YV: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half   = 1'b0;
                    n_i      = yv_val[22:16];
                    n_f      = yv_val[15:0];
                    n_r      = Q30_ONE;
                    n_second = 1'b1;
                    n_cnt    = 4'd0;
                    n_phase  = P_EXP;
                end
            end
            P_NV: begin
                if (!r_half) begin
                    n_half = 1'b1;
                end else if (!r_last || out_free) begin
                    commit  = 1'b1;
                    n_half  = 1'b0;
                    n_price = new_price;
                    n_vol   = nv;
                    n_clamp = r_clamp | price_neg | price_big;
                    if (r_last) begin
                        n_out_valid         = 1'b1;
                        n_out.final_price   = new_price;
                        n_out.final_vol     = nv;
                        n_out.price_clamped = r_clamp | price_neg | price_big;
                    end
                    n_phase = P_IDLE;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_cnt       <= 4'd0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
            r_price     <= 31'd0;
            r_vol       <= 31'd0;
            r_clamp     <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
            r_price     <= n_price;
            r_vol       <= n_vol;
            r_clamp     <= n_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= mul_a * mul_b;
        r_second <= n_second;
        r_out    <= n_out;
        r_n1     <= n_n1;
        r_n2     <= n_n2;
        r_last   <= n_last;
        r_beta   <= n_beta;
        r_m      <= n_m;
        r_p      <= n_p;
        r_frac   <= n_frac;
        r_i      <= n_i;
        r_f      <= n_f;
        r_r      <= n_r;
        r_pw     <= n_pw;
        r_z1mag  <= n_z1mag;
        r_vp     <= n_vp;
        r_acc    <= n_acc;
        r_a      <= n_a;
        r_ex     <= n_ex;
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_last) |-> (!r_out_valid || i_pop))
        else $error("result register overwritten while still waiting");

    a_log_normalised: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_LOG) |-> r_m[30])
        else $error("log mantissa lost its leading one");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_EXP) |-> ($signed(r_i) >= -7'sd47 && $signed(r_i) <= 7'sd46))
        else $error("exponent integer part out of range");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_IDLE) |-> !r_half)
        else $error("multiply half-step left pending at idle");

endmodule

### hw/rtl/sabr_path_step.sv
// top level of the sabr path stepper: configuration registers, step queue, stepper
// depends on sabr_pkg, sabr_front and sabr_back
//
// use:
//   steps are pushed through push/full with i_in_item; a transfer happens when
//   push is high and full is low. the two-entry step queue keeps taking steps
//   while the stepper is busy.
//   results appear at o_out_item while empty is low and leave on pop.
//   only a step flagged path_end makes a result; one result register sits at
//   the output, so a stalled receiver holds the stepper at its last cycle
//   while the step queue keeps filling.
//   configuration is written through i_cfg_valid/o_cfg_ready with a register
//   index and data; ready is always high. write only while no step is in flight.
//   operation: the stepper takes one step at a time through a single shared
//   32x32 multiplier. a step with a nonzero price runs a normalisation, 16
//   squarings for log2, two 16-factor exp2 runs in which a clear fraction bit
//   skips its multiply, and twelve more multiplies; a zero price skips the
//   normalisation, log2, its scaling and the first exp2 run.
//   reset (synchronous, active low) restores the register defaults, clears
//   price, volatility and the clamp flag, and empties queue and output.
module sabr_path_step import sabr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_item    i_in_item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg    r_cfg, n_cfg;
    t_q_view q_view;
    logic    q_pop;
    logic    out_valid;

    assign o_cfg_ready = 1'b1;
    assign empty       = !out_valid;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INITIAL_PRICE:     n_cfg.initial_price     = i_cfg_data[30:0];
                REG_INITIAL_VOL:       n_cfg.initial_vol       = i_cfg_data[30:0];
                REG_GROWTH_FACTOR:     n_cfg.growth_factor     = i_cfg_data[30:0];
                REG_SQRT_STEP:         n_cfg.sqrt_step         = i_cfg_data[30:0];
                REG_ELASTICITY:        n_cfg.elasticity        = i_cfg_data[16:0];
                REG_VOL_DRIFT:         n_cfg.vol_drift         = i_cfg_data;
                REG_VOL_WEIGHT_FIRST:  n_cfg.vol_weight_first  = i_cfg_data;
                REG_VOL_WEIGHT_SECOND: n_cfg.vol_weight_second = i_cfg_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_price     <= 31'd6553600;
            r_cfg.initial_vol       <= 31'd32768;
            r_cfg.growth_factor     <= 31'd65536;
            r_cfg.sqrt_step         <= 31'd65536;
            r_cfg.elasticity        <= 17'd32768;
            r_cfg.vol_drift         <= 32'sd0;
            r_cfg.vol_weight_first  <= 32'sd0;
            r_cfg.vol_weight_second <= 32'sd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    sabr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_in_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_q     (q_view)
    );

    sabr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q         (q_view),
        .o_q_pop     (q_pop),
        .o_out       (o_out_item),
        .o_out_valid (out_valid),
        .i_pop       (pop)
    );

endmodule

### dv/sabr_path_step_test.sv
// testbench for the sabr path stepper: directed and random paths checked against
// a bit-exact fixed-point predictor; depends on sabr_pkg and sabr_path_step
module sabr_path_step_test import sabr_pkg::*; ();

    localparam logic [63:0] WIDE_CAP = 64'h0004_0000_0000_0000;
    localparam logic [63:0] MAG_CAP  = 64'h0000_0100_0000_0000;
    localparam int SETTLE_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    t_in_item    i_in_item;
    logic        full;
    logic        empty;
    logic        pop;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    sabr_path_step u_top (.*);

    // predictor state and register copy
    t_cfg        model_cfg;
    logic [31:0] path_price;
    logic [31:0] path_vol;
    bit          path_clamp;
    t_out_item   pending_finals[$];

    int  errors;
    int  steps_sent;
    int  finals_seen;
    int  clamped_seen;
    bit  calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("sabr_path_step_test failed");
        $finish;
    end

    function automatic logic [63:0] absv(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // exact product, truncated by 2^t (left shift when t is negative), capped
    function automatic logic [63:0] scale_mul(input logic [63:0] a, input logic [63:0] b,
                                              input int t, input logic [63:0] cap);
        logic [191:0] w;
        w = 192'(128'(a) * 128'(b));
        if (t >= 0) begin
            w = w >> t;
        end else begin
            if (-t >= 64) return (w != 0) ? cap : 64'd0;
            w = w << (-t);
        end
        if (w > 192'(cap)) return cap;
        return w[63:0];
    endfunction

    function automatic longint smul_q(input longint a, input longint b, input int t,
                                      input logic [63:0] cap);
        logic [63:0] r;
        r = scale_mul(absv(a), absv(b), t, cap);
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x_in);
        logic [63:0] x, res, bv;
        x = x_in;
        res = 0;
        bv = 64'h4000_0000_0000_0000;
        while (bv > x) bv = bv >> 2;
        while (bv != 0) begin
            if (x >= res + bv) begin
                x = x - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    // 2^y split into integer power and a q1.30 mantissa
    task automatic pow2_split(input longint y, output longint pow_int,
                              output logic [63:0] mant);
        logic [63:0] f, t;
        longint i;
        mant = 64'h4000_0000;
        t = 64'h8000_0000;
        if (y >= 0) i = y >>> 16;
        else i = -longint'((absv(y) + 65535) >> 16);
        f = 64'(y - i * 65536);
        for (int k = 1; k <= 16; k++) begin
            t = int_sqrt(t << 30);
            if (f[16-k]) mant = (mant * t) >> 30;
        end
        pow_int = i;
    endtask

    function automatic longint log2_q16(input logic [31:0] s);
        int p;
        logic [63:0] m;
        longint frac;
        p = 30;
        frac = 0;
        while (p > 0 && !s[p]) p--;
        m = 64'(s) << (30 - p);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return longint'(p - 16) * 65536 + frac;
    endfunction

    // one euler step of the path; returns 1 when the step ends a path
    task automatic predict_step(input t_in_item it, output bit has_final,
                                output t_out_item fin);
        longint n1, n2, pw_i, y, z1, sum, ex, yv;
        logic [63:0] beta, pw, mant, vp, bm, lin, nv;
        n1 = longint'(it.normal_first);
        n2 = longint'(it.normal_second);
        if (it.path_start) begin
            path_price = 32'(model_cfg.initial_price);
            path_vol = 32'(model_cfg.initial_vol);
            path_clamp = 1'b0;
        end
        beta = (model_cfg.elasticity > BETA_ONE) ? 64'(BETA_ONE) : 64'(model_cfg.elasticity);
        if (path_price == 0) begin
            pw = (beta == 0) ? 64'd65536 : 64'd0;
        end else begin
            y = smul_q(log2_q16(path_price), longint'(beta), 16, WIDE_CAP);
            pow2_split(y, pw_i, mant);
            pw = scale_mul(mant, 64'd1, int'(14 - pw_i), 64'(PRICE_MAX));
        end
        z1 = smul_q(n1, longint'(model_cfg.sqrt_step), 16, WIDE_CAP);
        vp = scale_mul(64'(path_vol), pw, 16, WIDE_CAP);
        bm = scale_mul(vp, absv(z1), 16, MAG_CAP);
        lin = scale_mul(64'(path_price), 64'(model_cfg.growth_factor), 16, WIDE_CAP);
        sum = (z1 < 0) ? longint'(lin) - longint'(bm) : longint'(lin) + longint'(bm);
        ex = longint'(model_cfg.vol_drift)
           + smul_q(longint'(model_cfg.vol_weight_first), n1, 16, WIDE_CAP)
           + smul_q(longint'(model_cfg.vol_weight_second), n2, 16, WIDE_CAP);
        if (ex > longint'(EXP_LIM)) ex = longint'(EXP_LIM);
        if (ex < -longint'(EXP_LIM)) ex = -longint'(EXP_LIM);
        yv = smul_q(ex, longint'(LOG2E_Q30), 30, WIDE_CAP);
        pow2_split(yv, pw_i, mant);
        nv = scale_mul(64'(path_vol), mant, int'(30 - pw_i), 64'(PRICE_MAX));
        if (sum < 0) begin
            path_price = 0;
            path_clamp = 1'b1;
        end else if (sum > longint'(PRICE_MAX)) begin
            path_price = 32'(PRICE_MAX);
            path_clamp = 1'b1;
        end else begin
            path_price = 32'(sum);
        end
        path_vol = 32'(nv);
        has_final = it.path_end;
        fin.final_price = path_price[30:0];
        fin.final_vol = path_vol[30:0];
        fin.price_clamped = path_clamp;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_INITIAL_PRICE:     model_cfg.initial_price = data[30:0];
            REG_INITIAL_VOL:       model_cfg.initial_vol = data[30:0];
            REG_GROWTH_FACTOR:     model_cfg.growth_factor = data[30:0];
            REG_SQRT_STEP:         model_cfg.sqrt_step = data[30:0];
            REG_ELASTICITY:        model_cfg.elasticity = data[16:0];
            REG_VOL_DRIFT:         model_cfg.vol_drift = data;
            REG_VOL_WEIGHT_FIRST:  model_cfg.vol_weight_first = data;
            default:               model_cfg.vol_weight_second = data;
        endcase
    endtask

    task automatic cfg_all(input logic [31:0] ip, input logic [31:0] iv, input logic [31:0] g,
                           input logic [31:0] sq, input logic [31:0] b, input logic [31:0] d,
                           input logic [31:0] w1, input logic [31:0] w2);
        cfg_write(REG_INITIAL_PRICE, ip);
        cfg_write(REG_INITIAL_VOL, iv);
        cfg_write(REG_GROWTH_FACTOR, g);
        cfg_write(REG_SQRT_STEP, sq);
        cfg_write(REG_ELASTICITY, b);
        cfg_write(REG_VOL_DRIFT, d);
        cfg_write(REG_VOL_WEIGHT_FIRST, w1);
        cfg_write(REG_VOL_WEIGHT_SECOND, w2);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every result, then for steps without a result still in flight
    task automatic settle();
        while (pending_finals.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_step(input logic [31:0] n1, input logic [31:0] n2,
                             input bit st, input bit en);
        t_in_item it;
        t_out_item fin;
        bit has_final;
        it.normal_first = n1;
        it.normal_second = n2;
        it.path_start = st;
        it.path_end = en;
        if (!calm && $urandom_range(0, 99) < 28) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        steps_sent++;
        predict_step(it, has_final, fin);
        if (has_final) pending_finals.push_back(fin);
    endtask

    task automatic stop_sending();
        push <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_normal();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 131072) + $urandom_range(0, 131072)
             + $urandom_range(0, 131072) + $urandom_range(0, 131072) - 32'd262144;
    endfunction

    // result check and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_finals.size() == 0) begin
                $error("result with nothing expected: %p", o_out_item);
                errors++;
            end else begin
                t_out_item want;
                want = pending_finals.pop_front();
                finals_seen++;
                if (want.price_clamped) clamped_seen++;
                if (o_out_item.final_price !== want.final_price) begin
                    $error("final_price expected %0d actual %0d",
                           want.final_price, o_out_item.final_price);
                    errors++;
                end
                if (o_out_item.final_vol !== want.final_vol) begin
                    $error("final_vol expected %0d actual %0d",
                           want.final_vol, o_out_item.final_vol);
                    errors++;
                end
                if (o_out_item.price_clamped !== want.price_clamped) begin
                    $error("price_clamped expected %0d actual %0d",
                           want.price_clamped, o_out_item.price_clamped);
                    errors++;
                end
            end
        end
        pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end

    // a step before any path start runs from the cleared state
    task automatic test_cleared_state();
        send_step(32'd65536, 32'd0, 1'b0, 1'b1);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
    endtask

    task automatic test_default_paths();
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_step(32'd0, 32'd0, 1'b1, 1'b0);
        send_step(32'd65536, -32'sd65536, 1'b0, 1'b0);
        send_step(-32'sd131072, 32'd98304, 1'b0, 1'b1);
        // continue after the end without a restart
        send_step(32'd32768, 32'd32768, 1'b0, 1'b1);
        send_step(32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1);
        stop_sending();
        settle();
    endtask

    task automatic test_extreme_settings();
        // every register at its top: price saturates; volatility saturates on the upward step
        cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h0001_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_step(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
        stop_sending();
        settle();
        // bottom values: zero price with zero beta, huge negative exponent
        cfg_all(32'd0, 32'd65536, 32'd0, 32'd65536,
                32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_step(32'd65536, 32'd65536, 1'b1, 1'b0);
        send_step(-32'sd65536, 32'd0, 1'b0, 1'b1);
        stop_sending();
        settle();
        // a large downward shock clamps the price at zero
        cfg_all(32'd65536, 32'd655360, 32'd65536, 32'd65536,
                32'd65536, 32'd0, 32'd6553, 32'd6553);
        send_step(-32'sd327680, 32'd0, 1'b1, 1'b1);
        send_step(32'd0, 32'd0, 1'b1, 1'b0);
        send_step(32'd0, 32'd0, 1'b0, 1'b1);
        stop_sending();
        settle();
    endtask

    task automatic test_random_paths(input int target);
        int len;
        int sent;
        sent = 0;
        for (int phase = 0; sent < target; phase++) begin
            calm = (phase == 1);
            if (phase % 3 == 2) begin
                cfg_all($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
            end else begin
                cfg_all($urandom_range(65536, 200 * 65536), $urandom_range(3277, 65536),
                        65536 + $urandom_range(0, 200), 65536 >> $urandom_range(1, 6),
                        $urandom_range(0, 65536), -$urandom_range(0, 4000),
                        $urandom_range(0, 40000) - 20000, $urandom_range(0, 20000));
            end
            for (int p = 0; p < 30 && sent < target; p++) begin
                len = $urandom_range(1, 12);
                for (int s = 0; s < len; s++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_step(rand_normal(), rand_normal(), $urandom_range(0, 1),
                                  $urandom_range(0, 1));
                    else
                        send_step(rand_normal(), rand_normal(), s == 0, s == len - 1);
                    sent++;
                end
            end
            stop_sending();
            settle();
        end
        calm = 1'b0;
    endtask

    initial begin
        errors = 0;
        steps_sent = 0;
        finals_seen = 0;
        clamped_seen = 0;
        calm = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        model_cfg.initial_price = 31'd6553600;
        model_cfg.initial_vol = 31'd32768;
        model_cfg.growth_factor = Q16_ONE;
        model_cfg.sqrt_step = Q16_ONE;
        model_cfg.elasticity = 17'd32768;
        model_cfg.vol_drift = 0;
        model_cfg.vol_weight_first = 0;
        model_cfg.vol_weight_second = 0;
        path_price = 0;
        path_vol = 0;
        path_clamp = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_state();
        test_default_paths();
        test_extreme_settings();
        test_random_paths(1650);

        settle();
        $display("covered %0d steps and %0d path results, %0d of them clamped",
                 steps_sent, finals_seen, clamped_seen);
        if (errors == 0 && pending_finals.size() == 0) begin
            $display("sabr_path_step_test passed");
        end else begin
            $display("sabr_path_step_test failed");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/sabr_pkg.sv
hw/rtl/sabr_front.sv
hw/rtl/sabr_back.sv
hw/rtl/sabr_path_step.sv
dv/sabr_path_step_test.sv
